// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: src/lzfbd_pkg.sv
package lzfbd_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 65536;
  localparam int unsigned DRAIN_BURST_DEF  = 64;

  localparam int unsigned HDR_SIZE_FIRST = 4;
  localparam int unsigned HDR_SIZE_LAST  = 7;
  localparam int unsigned HDR_FLAG_IDX   = 8;
  localparam int unsigned HDR_LEN        = 9;
  localparam int unsigned MIN_MATCH      = 4;
  localparam int unsigned LEN_LOW_SHIFT  = 3;
  localparam int unsigned LEN_EXT_SHIFT  = 5;
  localparam int unsigned EXT_BIT        = 2;

  localparam int unsigned LEN_W  = 14;
  localparam int unsigned OFS_W  = 24;
  localparam int unsigned BR_W   = 32;
  localparam int unsigned HIDX_W = 4;

  localparam logic [1:0] OFS_RESERVED = 2'd3;

  typedef enum logic {
    OP_PUSH,
    OP_DRAIN
  } op_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDLE,
    PH_CODE,
    PH_EXT,
    PH_OFFSET,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_RESERVED,
    ERR_DISTANCE,
    ERR_PUSH_COPY,
    ERR_SHORT
  } err_e;

  typedef enum logic {
    DR_IDLE,
    DR_RUN
  } dr_state_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       copy_pending;
    logic       stream_done;
    err_e       error_code;
  } rsp_t;

endpackage

// File: src/lzfbd_req_if.sv
interface lzfbd_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;

  modport source (output valid, output operation, output in_byte, input ready);
  modport sink (input valid, input operation, input in_byte, output ready);
endinterface

// File: src/lzfbd_rsp_if.sv
interface lzfbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       copy_pending;
  logic       stream_done;
  logic [2:0] error_code;

  modport source (
    output valid, output out_byte, output has_byte, output last_of_run,
    output copy_pending, output stream_done, output error_code, input ready
  );
  modport sink (
    input valid, input out_byte, input has_byte, input last_of_run,
    input copy_pending, input stream_done, input error_code, output ready
  );
endinterface

// File: src/lzfbd_ram.sv
module lzfbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/lz_flag_byte_decompressor.sv
// Push: one request per cycle unless the output stalls; its result is registered and shown
// in the cycle after acceptance. Drain: N = min(pending copy, DRAIN_BURST) results; the first
// goes through the sequencer state, a RAM read and the result register, then one per cycle
// unless the output stalls, paced by the history RAM's single read port; no request meanwhile.
// A drain with no copy pending gives one result in the cycle after acceptance. Reset (async,
// active low) clears parse state, counters and the valid flag, not result data or history RAM.
`include "assert_macros.svh"
module lz_flag_byte_decompressor import lzfbd_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int unsigned DRAIN_BURST  = DRAIN_BURST_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  lzfbd_req_if.sink   req_i,
  lzfbd_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned PW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned BW = $clog2(DRAIN_BURST + 1);

  dr_state_e          dr_state_q, dr_state_d;
  phase_e             phase_q, phase_d;
  logic [HIDX_W-1:0]  hidx_q, hidx_d;
  logic [BR_W-1:0]    br_q, br_d;
  logic [7:0]         flag_q, flag_d;
  logic [LEN_W-1:0]   la_q, la_d;
  logic [1:0]         ot_q, ot_d;
  logic [OFS_W-1:0]   oa_q, oa_d;
  logic [1:0]         obl_q, obl_d;
  logic [LEN_W-1:0]   cl_q, cl_d;
  logic [PW-1:0]      cd_q, cd_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic [PW-1:0]      bp_q, bp_d;
  logic [BW-1:0]      issue_left_q, issue_left_d;
  logic [BW-1:0]      out_left_q, out_left_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      rp_q, rp_d;
  logic               fwd_q, fwd_d;
  logic [7:0]         fwd_byte_q, fwd_byte_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic               req_ready;
  logic               req_acc;
  logic               can_load;
  logic               consume;
  logic               re;
  logic               drain_start;
  logic               load;
  logic               put;
  logic [7:0]         put_byte;
  logic [7:0]         ram_rdata;
  logic [7:0]         drain_byte;
  logic               done_now;
  logic               done_d;
  err_e               push_err;
  logic               push_has;
  logic [7:0]         push_lit;
  logic [7:0]         t_byte;
  logic [1:0]         ofs_idx;
  logic [OFS_W:0]     match_dist;
  logic [PW:0]        rp_sum;
  logic [PW:0]        rp_wrap;
  logic [BW-1:0]      burst_n;

  assign can_load    = !out_valid_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_ready;
  assign req_i.ready = req_ready;
  assign drain_start = req_acc && (req_i.operation == OP_DRAIN) && (cl_q != '0);
  assign drain_byte  = fwd_q ? fwd_byte_q : ram_rdata;
  assign done_now    = (phase_q == PH_DONE) ||
                       ((phase_q != PH_HEADER) && (br_q == '0) && (cl_q == '0));
  assign done_d      = (phase_d == PH_DONE) ||
                       ((phase_d != PH_HEADER) && (br_d == '0) && (cl_d == '0));

  // drain sequencer: next state
  always_comb begin
    dr_state_d = dr_state_q;
    unique case (dr_state_q)
      DR_IDLE: begin
        if (drain_start) begin
          dr_state_d = DR_RUN;
        end
      end
      DR_RUN: begin
        if (consume && (out_left_q == BW'(1))) begin
          dr_state_d = DR_IDLE;
        end
      end
      default: dr_state_d = DR_IDLE;
    endcase
  end

  // drain sequencer: outputs
  always_comb begin
    req_ready = 1'b0;
    consume   = 1'b0;
    re        = 1'b0;
    unique case (dr_state_q)
      DR_IDLE: begin
        req_ready = can_load;
      end
      DR_RUN: begin
        consume = pend_q && can_load;
        re      = (issue_left_q != '0) && (!pend_q || consume);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cl_q < LEN_W'(DRAIN_BURST)) begin
      burst_n = BW'(cl_q);
    end else begin
      burst_n = BW'(DRAIN_BURST);
    end
    rp_sum  = (PW+1)'(wp_q) + (PW+1)'(WINDOW_BYTES) - (PW+1)'(cd_q);
    rp_wrap = rp_sum;
    if (rp_sum >= (PW+1)'(WINDOW_BYTES)) begin
      rp_wrap = rp_sum - (PW+1)'(WINDOW_BYTES);
    end
  end

  // burst counters, read pointer and same-entry forwarding
  always_comb begin
    issue_left_d = issue_left_q;
    out_left_d   = out_left_q;
    pend_d       = pend_q;
    rp_d         = rp_q;
    fwd_d        = fwd_q;
    fwd_byte_d   = fwd_byte_q;
    if (drain_start) begin
      issue_left_d = burst_n;
      out_left_d   = burst_n;
      rp_d         = AW'(rp_wrap);
    end
    if (re) begin
      issue_left_d = issue_left_q - BW'(1);
      rp_d         = (rp_q == AW'(WINDOW_BYTES - 1)) ? '0 : rp_q + AW'(1);
      fwd_d        = consume && (rp_q == wp_q);
      fwd_byte_d   = drain_byte;
      pend_d       = 1'b1;
    end else if (consume) begin
      pend_d = 1'b0;
    end
    if (consume) begin
      out_left_d = out_left_q - BW'(1);
    end
  end

  // parse one compressed byte, retire one copied byte
  always_comb begin
    phase_d    = phase_q;
    hidx_d     = hidx_q;
    br_d       = br_q;
    flag_d     = flag_q;
    la_d       = la_q;
    ot_d       = ot_q;
    oa_d       = oa_q;
    obl_d      = obl_q;
    cl_d       = cl_q;
    cd_d       = cd_q;
    wp_d       = wp_q;
    bp_d       = bp_q;
    put        = 1'b0;
    put_byte   = '0;
    push_err   = ERR_NONE;
    push_has   = 1'b0;
    push_lit   = '0;
    t_byte     = '0;
    ofs_idx    = '0;
    match_dist = '0;
    if (req_acc && (req_i.operation == OP_PUSH)) begin
      priority if (cl_q != '0) begin
        push_err = ERR_PUSH_COPY;
      end else if (done_now) begin
      end else if (phase_q == PH_HEADER) begin
        if ((hidx_q >= HIDX_W'(HDR_SIZE_FIRST)) && (hidx_q <= HIDX_W'(HDR_SIZE_LAST))) begin
          br_d[{hidx_q[1:0], 3'b000} +: 8] = br_q[{hidx_q[1:0], 3'b000} +: 8] | req_i.in_byte;
        end
        if (hidx_q >= HIDX_W'(HDR_FLAG_IDX)) begin
          flag_d = req_i.in_byte;
          hidx_d = '0;
          if (br_q < BR_W'(HDR_LEN)) begin
            push_err = ERR_SHORT;
            br_d     = '0;
            phase_d  = PH_DONE;
          end else begin
            br_d    = br_q - BR_W'(HDR_LEN);
            phase_d = PH_IDLE;
          end
        end else begin
          hidx_d = hidx_q + HIDX_W'(1);
        end
      end else begin
        br_d = br_q - BR_W'(1);
        unique case (phase_q)
          PH_IDLE: begin
            if (req_i.in_byte != flag_q) begin
              push_has = 1'b1;
              push_lit = req_i.in_byte;
            end else begin
              phase_d = PH_CODE;
            end
          end
          PH_CODE: begin
            if (req_i.in_byte == flag_q) begin
              push_has = 1'b1;
              push_lit = req_i.in_byte;
              phase_d  = PH_IDLE;
            end else begin
              t_byte = req_i.in_byte - ((req_i.in_byte > flag_q) ? 8'd1 : 8'd0);
              la_d   = LEN_W'(t_byte >> LEN_LOW_SHIFT);
              ot_d   = t_byte[1:0];
              if (t_byte[1:0] == OFS_RESERVED) begin
                push_err = ERR_RESERVED;
                phase_d  = PH_IDLE;
              end else if (t_byte[EXT_BIT]) begin
                phase_d = PH_EXT;
              end else begin
                obl_d   = t_byte[1:0] + 2'd1;
                oa_d    = '0;
                phase_d = PH_OFFSET;
              end
            end
          end
          PH_EXT: begin
            la_d    = LEN_W'(la_q[LEN_EXT_SHIFT-1:0]) | (LEN_W'(req_i.in_byte) << LEN_EXT_SHIFT);
            obl_d   = ot_q + 2'd1;
            oa_d    = '0;
            phase_d = PH_OFFSET;
          end
          PH_OFFSET: begin
            ofs_idx = ot_q + 2'd1 - obl_q;
            unique case (ofs_idx)
              2'd0:    oa_d[7:0]   = oa_q[7:0] | req_i.in_byte;
              2'd1:    oa_d[15:8]  = oa_q[15:8] | req_i.in_byte;
              2'd2:    oa_d[23:16] = oa_q[23:16] | req_i.in_byte;
              default: ;
            endcase
            obl_d = obl_q - 2'd1;
            if (obl_q == 2'd1) begin
              match_dist = {1'b0, oa_d} + (OFS_W+1)'(1);
              if (match_dist > (OFS_W+1)'(bp_q)) begin
                push_err = ERR_DISTANCE;
              end else begin
                cl_d = la_q + LEN_W'(MIN_MATCH);
                cd_d = PW'(match_dist);
              end
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
        if ((br_d == '0) && (phase_d != PH_IDLE)) begin
          phase_d = PH_IDLE;
        end
        put      = push_has;
        put_byte = push_lit;
      end
    end else if (consume) begin
      cl_d     = cl_q - LEN_W'(1);
      put      = 1'b1;
      put_byte = drain_byte;
    end
    if (put) begin
      wp_d = (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + AW'(1);
      if (bp_q != PW'(WINDOW_BYTES)) begin
        bp_d = bp_q + PW'(1);
      end
    end
  end

  // result register
  always_comb begin
    load        = consume || (req_acc && !drain_start);
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    out_d              = out_q;
    out_d.copy_pending = (cl_d != '0);
    out_d.stream_done  = done_d;
    if (consume) begin
      out_d.out_byte    = drain_byte;
      out_d.has_byte    = 1'b1;
      out_d.last_of_run = (out_left_q == BW'(1));
      out_d.error_code  = ERR_NONE;
    end else begin
      out_d.out_byte    = push_lit;
      out_d.has_byte    = push_has;
      out_d.last_of_run = 1'b1;
      out_d.error_code  = push_err;
    end
  end

  lzfbd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (put),
    .waddr_i (wp_q),
    .wdata_i (put_byte),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dr_state_q   <= DR_IDLE;
      phase_q      <= PH_HEADER;
      hidx_q       <= '0;
      br_q         <= '0;
      flag_q       <= '0;
      la_q         <= '0;
      ot_q         <= '0;
      oa_q         <= '0;
      obl_q        <= '0;
      cl_q         <= '0;
      cd_q         <= '0;
      wp_q         <= '0;
      bp_q         <= '0;
      issue_left_q <= '0;
      out_left_q   <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      dr_state_q   <= dr_state_d;
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      br_q         <= br_d;
      flag_q       <= flag_d;
      la_q         <= la_d;
      ot_q         <= ot_d;
      oa_q         <= oa_d;
      obl_q        <= obl_d;
      cl_q         <= cl_d;
      cd_q         <= cd_d;
      wp_q         <= wp_d;
      bp_q         <= bp_d;
      issue_left_q <= issue_left_d;
      out_left_q   <= out_left_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q       <= rp_d;
    fwd_q      <= fwd_d;
    fwd_byte_q <= fwd_byte_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.out_byte     = out_q.out_byte;
  assign rsp_o.has_byte     = out_q.has_byte;
  assign rsp_o.last_of_run  = out_q.last_of_run;
  assign rsp_o.copy_pending = out_q.copy_pending;
  assign rsp_o.stream_done  = out_q.stream_done;
  assign rsp_o.error_code   = out_q.error_code;

  `ASSERT_IMPLIES(a_run_has_copy, clk_i, rst_ni, dr_state_q == DR_RUN, cl_q != '0)
  `ASSERT_IMPLIES(a_pend_in_run, clk_i, rst_ni, pend_q, dr_state_q == DR_RUN)
  `ASSERT_IMPLIES(a_dist_in_window, clk_i, rst_ni, dr_state_q == DR_RUN, (cd_q <= bp_q) && (cd_q != '0))
  `ASSERT_NEXT(a_burst_ends, clk_i, rst_ni, consume && (out_left_q == BW'(1)), (dr_state_q == DR_IDLE) && !pend_q)

endmodule
